[hw/rtl/pspm_pkg.sv]
// ---------------------------------------------------------------------------
// pspm_pkg
// Shared widths, reset values and register indexes of the pause mapper.
// ---------------------------------------------------------------------------
package pspm_pkg;

    // converter sample and filter
    localparam int SAMPLE_BITS   = 10;
    localparam int ALPHA_SHIFT   = 3;
    localparam int SUM_BITS      = SAMPLE_BITS + ALPHA_SHIFT;

    // pause and deadband registers
    localparam int PAUSE_BITS    = 22;
    localparam int DEADBAND_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    // level * span product and its division by the full-scale code
    localparam int PROD_BITS     = SAMPLE_BITS + PAUSE_BITS;
    localparam int DIV_TERMS     = (PROD_BITS - 1) / SAMPLE_BITS;
    localparam int REM_BITS      = SAMPLE_BITS + 2;
    localparam int CORR_BITS     = 2;

    // stream word widths, padded to whole bytes
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_USED_BITS = PAUSE_BITS + 1 + SAMPLE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

    localparam logic [PAUSE_BITS-1:0]    RESET_MIN      = PAUSE_BITS'(90000);
    localparam logic [PAUSE_BITS-1:0]    RESET_MAX      = PAUSE_BITS'(400000);
    localparam logic [DEADBAND_BITS-1:0] RESET_DEADBAND = DEADBAND_BITS'(2000);
    localparam logic [PAUSE_BITS-1:0]    RESET_HELD     = PAUSE_BITS'(90000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PAUSE_MIN = 2'd0,
        CFG_PAUSE_MAX = 2'd1,
        CFG_DEADBAND  = 2'd2
    } t_cfg_idx;

endpackage

[hw/rtl/pot_smoothing_pause_mapper_unit.sv]
// ---------------------------------------------------------------------------
// pot_smoothing_pause_mapper_unit
// Potentiometer smoothing filter, inverse linear pause map and hysteresis.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per converter sample, sample in tdata[9:0].
//   Master stream: one word per sample with the held pause, an update flag
//   and the filtered level.
//   Config port: i_cfg_wen with i_cfg_idx selects pause_min (0), pause_max
//   (1) or deadband (2); other indexes are ignored. Write only while idle.
// Timing:
//   Five register stages: filter, multiply, divide estimate, map, deadband.
//   A word accepted on the slave side passes the filter, multiply, divide
//   estimate and map registers into the deadband output register; throughput
//   is one word per cycle while the receiver is ready. Stage two holds the
//   10x22 multiplier, the other stages hold short adds and compares.
// Reset:
//   Synchronous, active low. Clears the pipeline, restores the register
//   defaults, unseeds the filter and sets the held pause to 90000 us.
// Stall:
//   A stalled receiver freezes only the stages that are full; bubbles still
//   fill, so input is refused only when all five stages hold words.
// ---------------------------------------------------------------------------
module pot_smoothing_pause_mapper_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave stream; tdata: raw_sample[9:0], zero pad [15:10]
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [pspm_pkg::IN_DATA_BITS-1:0]      i_s_axis_tdata,
    // master stream; tdata: pause_after_us[21:0], pause_updated[22],
    // filtered_level[32:23], zero pad [39:33]
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [pspm_pkg::OUT_DATA_BITS-1:0]     o_m_axis_tdata,
    // configuration write port
    input  logic                                   i_cfg_wen,
    input  logic [pspm_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [pspm_pkg::PAUSE_BITS-1:0]        i_cfg_wdata
);

    localparam int SB = pspm_pkg::SAMPLE_BITS;
    localparam int PB = pspm_pkg::PAUSE_BITS;
    localparam int DB = pspm_pkg::DEADBAND_BITS;
    localparam int XB = pspm_pkg::PROD_BITS;
    localparam int RB = pspm_pkg::REM_BITS;

    // configuration registers
    logic [PB-1:0] r_pause_min;
    logic [PB-1:0] r_pause_max;
    logic [DB-1:0] r_deadband;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_min <= pspm_pkg::RESET_MIN;
            r_pause_max <= pspm_pkg::RESET_MAX;
            r_deadband  <= pspm_pkg::RESET_DEADBAND;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                pspm_pkg::CFG_PAUSE_MIN: r_pause_min <= i_cfg_wdata;
                pspm_pkg::CFG_PAUSE_MAX: r_pause_max <= i_cfg_wdata;
                pspm_pkg::CFG_DEADBAND:  r_deadband  <= i_cfg_wdata[DB-1:0];
                default: ;
            endcase
        end
    end

    // pipeline occupancy and per-stage advance
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic adv1, adv2, adv3, adv4, adv5;
    logic in_accept;

    assign adv5 = !r_out_valid || i_m_axis_tready;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_s_axis_tready = adv1;
    assign in_accept       = i_s_axis_tvalid && adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv1) r_v1        <= i_s_axis_tvalid;
            if (adv2) r_v2        <= r_v1;
            if (adv3) r_v3        <= r_v2;
            if (adv4) r_v4        <= r_v3;
            if (adv5) r_out_valid <= r_v4;
        end
    end

    // stage 1: exponential moving average; r_level is the filter state itself
    logic [SB-1:0]                  r_level;
    logic                           r_seeded;
    logic [SB-1:0]                  sample;
    logic [pspm_pkg::SUM_BITS-1:0]  avg_sum;
    logic [SB-1:0]                  n_level;

    assign sample = i_s_axis_tdata[SB-1:0];

    always_comb begin
        // level * (2^A - 1) + sample, kept exact
        avg_sum = {r_level, {pspm_pkg::ALPHA_SHIFT{1'b0}}}
                - pspm_pkg::SUM_BITS'(r_level)
                + pspm_pkg::SUM_BITS'(sample);
        if (r_seeded) begin
            n_level = avg_sum[pspm_pkg::SUM_BITS-1:pspm_pkg::ALPHA_SHIFT];
        end else begin
            n_level = sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_seeded <= 1'b0;
        end else if (in_accept) begin
            r_level  <= n_level;
            r_seeded <= 1'b1;
        end
    end

    // stage 2: level * span; span is zero when min exceeds max
    logic [PB-1:0] span;
    logic [XB-1:0] r_prod;
    logic [SB-1:0] r_level2;

    assign span = (r_pause_max >= r_pause_min) ? (r_pause_max - r_pause_min) : '0;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_prod   <= XB'(r_level) * XB'(span);
            r_level2 <= r_level;
        end
    end

    // stage 3: quotient estimate for division by 2^SB - 1 and its remainder.
    // The estimate sums x >> SB*k and falls short by at most DIV_TERMS.
    logic [XB-1:0] est_sum;
    logic [XB-1:0] rem_full;
    logic [PB-1:0] r_est;
    logic [RB-1:0] r_rem;
    logic [SB-1:0] r_level3;

    always_comb begin
        est_sum = '0;
        for (int k = 1; k <= pspm_pkg::DIV_TERMS; k++) begin
            est_sum = est_sum + (r_prod >> (SB * k));
        end
        // x - est * (2^SB - 1), small and non-negative
        rem_full = r_prod - (est_sum << SB) + est_sum;
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r_est    <= est_sum[PB-1:0];
            r_rem    <= rem_full[RB-1:0];
            r_level3 <= r_level2;
        end
    end

    // stage 4: correct the quotient and map inversely. The mapped value
    // already lies in [min, max] (or equals max when min exceeds max), so
    // the clamp folds away.
    logic [pspm_pkg::CORR_BITS-1:0] corr;
    logic [PB-1:0]                  quot;
    logic [PB-1:0]                  r_mapped;
    logic [SB-1:0]                  r_level4;

    always_comb begin
        corr = '0;
        for (int i = 1; i <= pspm_pkg::DIV_TERMS; i++) begin
            if (r_rem >= RB'(i) * RB'(pspm_pkg::FULL_SCALE)) begin
                corr = corr + pspm_pkg::CORR_BITS'(1);
            end
        end
        quot = r_est + PB'(corr);
    end

    always_ff @(posedge i_clk) begin
        if (adv4 && r_v3) begin
            r_mapped <= r_pause_max - quot;
            r_level4 <= r_level3;
        end
    end

    // stage 5: deadband hysteresis on the held pause, output register
    logic [PB-1:0] r_held;
    logic          r_out_upd;
    logic [SB-1:0] r_out_level;
    logic [PB:0]   held_hi;
    logic [PB:0]   mapped_hi;
    logic          move;

    always_comb begin
        held_hi   = {1'b0, r_held} + (PB+1)'(r_deadband);
        mapped_hi = {1'b0, r_mapped} + (PB+1)'(r_deadband);
        move      = ({1'b0, r_mapped} > held_hi) || (mapped_hi < {1'b0, r_held});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= pspm_pkg::RESET_HELD;
        end else if (adv5 && r_v4 && move) begin
            r_held <= r_mapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5 && r_v4) begin
            r_out_upd   <= move;
            r_out_level <= r_level4;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = pspm_pkg::OUT_DATA_BITS'({r_out_level, r_out_upd, r_held});

endmodule

[hw/rtl/pspm_checker.sv]
// ---------------------------------------------------------------------------
// pspm_checker
// Port-level checks of the pause mapper, bound to the top level.
// ---------------------------------------------------------------------------
module pspm_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_s_axis_tready,
    input  logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    input  logic [pspm_pkg::OUT_DATA_BITS-1:0]     o_m_axis_tdata
);

    localparam int PB = pspm_pkg::PAUSE_BITS;

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    // input back-pressure only while the output is full and stalled
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input refused with room in the pipeline");

    // the pause of back-to-back words changes only with the update flag
    a_pause_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready ##1 (o_m_axis_tvalid && !o_m_axis_tdata[PB]) |->
            o_m_axis_tdata[PB-1:0] == $past(o_m_axis_tdata[PB-1:0]))
        else $error("held pause changed without update flag");

endmodule

bind pot_smoothing_pause_mapper_unit pspm_checker u_pspm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
